// ===== sv/sbc_pkg.sv =====
package sbc_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned ROUNDS       = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam int unsigned COUNT_W = $clog2(BLOCK_WORDS);
    localparam int unsigned ROUND_W = $clog2(ROUNDS);
    localparam int unsigned EMIT_W  = $clog2(DIGEST_WORDS);

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t HASH_IV [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               shift_word;
        logic               restart;
        logic               init_vars;
        logic               round_en;
        logic               expand;
        logic               add_en;
        logic [ROUND_W-1:0] round_idx;
        logic [EMIT_W-1:0]  emit_idx;
    } cmd_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/sbc_in_if.sv =====
interface sbc_in_if;
    logic                 valid;
    logic                 ready;
    logic [sbc_pkg::WORD_W-1:0] message_word;
    logic                 restart;

    modport source (output valid, output message_word, output restart, input ready);
    modport sink   (input valid, input message_word, input restart, output ready);
endinterface

// ===== sv/sbc_out_if.sv =====
interface sbc_out_if;
    logic                 valid;
    logic                 ready;
    logic [sbc_pkg::WORD_W-1:0] digest_word;
    logic                 last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

// ===== sv/sbc_ctrl.sv =====
module sbc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_restart,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output sbc_pkg::cmd_t cmd
);

    sbc_pkg::state_t                 state_reg, state_next;
    logic [sbc_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [sbc_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic [sbc_pkg::EMIT_W-1:0]      emit_reg, emit_next;
    logic                            in_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbc_pkg::ST_COLLECT;
            count_reg <= '0;
            round_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            emit_reg  <= emit_next;
        end
    end

    assign in_beat = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        emit_next  = emit_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.emit_idx   = emit_reg;
        cmd.expand     = (round_reg >= sbc_pkg::ROUND_W'(sbc_pkg::BLOCK_WORDS));

        unique case (state_reg)
            sbc_pkg::ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_beat)
                begin
                    cmd.shift_word = 1'b1;
                    cmd.restart    = in_restart;
                    if (in_restart)
                        count_next = sbc_pkg::COUNT_W'(1);
                    else if (count_reg == sbc_pkg::COUNT_W'(sbc_pkg::BLOCK_WORDS - 1))
                    begin
                        count_next    = '0;
                        cmd.init_vars = 1'b1;
                        round_next    = '0;
                        state_next    = sbc_pkg::ST_ROUND;
                    end
                    else
                        count_next = count_reg + sbc_pkg::COUNT_W'(1);
                end
            end
            sbc_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + sbc_pkg::ROUND_W'(1);
                if (round_reg == sbc_pkg::ROUND_W'(sbc_pkg::ROUNDS - 1))
                    state_next = sbc_pkg::ST_ADD;
            end
            sbc_pkg::ST_ADD:
            begin
                cmd.add_en = 1'b1;
                emit_next  = '0;
                state_next = sbc_pkg::ST_EMIT;
            end
            sbc_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    emit_next = emit_reg + sbc_pkg::EMIT_W'(1);
                    if (emit_reg == sbc_pkg::EMIT_W'(sbc_pkg::DIGEST_WORDS - 1))
                        state_next = sbc_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = sbc_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

// ===== sv/sbc_datapath.sv =====
module sbc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbc_pkg::cmd_t               cmd,
    input  logic [sbc_pkg::WORD_W-1:0]  message_word,
    output logic [sbc_pkg::WORD_W-1:0]  digest_word,
    output logic                        last_word
);

    // schedule shift line: entry 0 holds W[t-16]
    sbc_pkg::word_t w_reg   [sbc_pkg::BLOCK_WORDS];
    sbc_pkg::word_t var_reg [sbc_pkg::DIGEST_WORDS];
    sbc_pkg::word_t cv_reg  [sbc_pkg::DIGEST_WORDS];

    sbc_pkg::word_t wr, t1, t2, ch, maj;

    always_comb
    begin
        if (cmd.expand)
            wr = sbc_pkg::small_sigma1(w_reg[14]) + w_reg[9]
               + sbc_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        else
            wr = w_reg[0];

        ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
            ^ (var_reg[1] & var_reg[2]);
        t1  = var_reg[7] + sbc_pkg::big_sigma1(var_reg[4]) + ch
            + sbc_pkg::ROUND_K[cmd.round_idx] + wr;
        t2  = sbc_pkg::big_sigma0(var_reg[0]) + maj;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_word || cmd.round_en)
        begin
            for (int i = 0; i < sbc_pkg::BLOCK_WORDS - 1; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[sbc_pkg::BLOCK_WORDS-1] <= cmd.shift_word ? message_word : wr;
        end

        if (cmd.init_vars)
        begin
            for (int i = 0; i < sbc_pkg::DIGEST_WORDS; i++)
                var_reg[i] <= cv_reg[i];
        end
        else if (cmd.round_en)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbc_pkg::DIGEST_WORDS; i++)
                cv_reg[i] <= sbc_pkg::HASH_IV[i];
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < sbc_pkg::DIGEST_WORDS; i++)
                cv_reg[i] <= sbc_pkg::HASH_IV[i];
        end
        else if (cmd.add_en)
        begin
            for (int i = 0; i < sbc_pkg::DIGEST_WORDS; i++)
                cv_reg[i] <= cv_reg[i] + var_reg[i];
        end
    end

    assign digest_word = cv_reg[cmd.emit_idx];
    assign last_word   = (cmd.emit_idx == sbc_pkg::EMIT_W'(sbc_pkg::DIGEST_WORDS - 1));

endmodule

// ===== sv/sha256_block_compressor_top.sv =====
// channel  dir  payload                       beat
// msg      in   message_word[31:0], restart   valid & ready
// digest   out  digest_word[31:0], last_word  valid & ready
//
// A block takes 16 input beats, then 64 rounds (one round per cycle),
// an add into the chaining value and 8 output beats.
// Reset loads the initial hash values and clears the word count.
// Input is not taken while a block is compressed or emitted; a stalled
// output beat holds its word.
module sha256_block_compressor_top (
    input  logic        clk,
    input  logic        rst_n,
    sbc_in_if.sink      msg,
    sbc_out_if.source   digest
);

    sbc_pkg::cmd_t cmd;

    sbc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (msg.valid),
        .in_restart (msg.restart),
        .in_ready   (msg.ready),
        .out_valid  (digest.valid),
        .out_ready  (digest.ready),
        .cmd        (cmd)
    );

    sbc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (msg.message_word),
        .digest_word  (digest.digest_word),
        .last_word    (digest.last_word)
    );

endmodule

// ===== sim/sbc_digest_checker.sv =====
`timescale 1ns / 1ps

module sbc_digest_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    input  logic             msg_ready,
    input  sbc_pkg::word_t   message_word,
    input  logic             restart,
    input  logic             digest_valid,
    input  logic             digest_ready,
    input  sbc_pkg::word_t   digest_word,
    input  logic             last_word,
    output int unsigned      errors,
    output int unsigned      pending
);

    localparam logic [64*32-1:0] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [8*32-1:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    logic [31:0]  chain [8];
    logic [31:0]  sched [16];
    logic [3:0]   word_pos;
    int unsigned  err_count;
    int unsigned  beat_idx;
    digest_beat_t due;
    digest_beat_t digest_due [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic logic [31:0] ep0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] ep1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] mix0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ {10'b0, x[31:10]};
    endfunction

    function automatic void load_iv();
        for (int k = 0; k < 8; k++)
        begin
            chain[k] = IV[(7 - k) * 32 +: 32];
        end
    endfunction

    function automatic void fold_block();
        logic [31:0] v [8];
        logic [31:0] w;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int k = 0; k < 8; k++)
        begin
            v[k] = chain[k];
        end
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                w = sched[r];
            end
            else
            begin
                w = mix1(sched[(r - 2) % 16]) + sched[(r - 7) % 16]
                    + mix0(sched[(r - 15) % 16]) + sched[r % 16];
                sched[r % 16] = w;
            end
            t1 = v[7] + ep1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                 + RK[(63 - r) * 32 +: 32] + w;
            t2 = ep0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
        begin
            chain[k] = chain[k] + v[k];
        end
    endfunction

    function automatic void take_word(input logic [31:0] w, input logic first);
        if (first)
        begin
            load_iv();
            word_pos = '0;
        end
        sched[word_pos] = w;
        if (word_pos != 4'd15)
        begin
            word_pos = word_pos + 4'd1;
        end
        else
        begin
            word_pos = '0;
            fold_block();
            for (int k = 0; k < 8; k++)
            begin
                digest_due.push_back({chain[k], k == 7});
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_iv();
            for (int k = 0; k < 16; k++)
            begin
                sched[k] = '0;
            end
            word_pos  = '0;
            err_count = 0;
            beat_idx  = 0;
            digest_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (digest_due.size() == 0)
                begin
                    if (err_count < 10)
                        $display("digest beat %0d: none expected, got %h last %b",
                                 beat_idx, digest_word, last_word);
                    err_count++;
                end
                else
                begin
                    due = digest_due.pop_front();
                    if (digest_word !== due.word || last_word !== due.last)
                    begin
                        if (err_count < 10)
                            $display("digest beat %0d: expected %h last %b, got %h last %b",
                                     beat_idx, due.word, due.last, digest_word, last_word);
                        err_count++;
                    end
                end
                beat_idx++;
            end
            if (msg_valid && msg_ready)
                take_word(message_word, restart);
            errors  <= err_count;
            pending <= digest_due.size();
        end
    end

endmodule

// ===== sim/tb_sha256_block_compressor_top.sv =====
`timescale 1ns / 1ps

module tb_sha256_block_compressor_top;

    localparam logic [16*32-1:0] CORNER_BLOCK = {
        32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
        32'h7fffffff, 32'hfffffffe, 32'haaaaaaaa, 32'h55555555,
        32'hffffffff, 32'h00000000, 32'h0000ffff, 32'hffff0000,
        32'h80000000, 32'h00000000, 32'h00000000, 32'h00000200
    };
    localparam int unsigned RANDOM_WORDS = 64;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned errors;
    int unsigned pending;
    int unsigned words_sent;
    int unsigned burst_left;
    int unsigned calm_left;
    int unsigned stall_left;

    sbc_in_if  msg_if ();
    sbc_out_if digest_if ();

    sha256_block_compressor_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    sbc_digest_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_if.valid),
        .msg_ready    (msg_if.ready),
        .message_word (msg_if.message_word),
        .restart      (msg_if.restart),
        .digest_valid (digest_if.valid),
        .digest_ready (digest_if.ready),
        .digest_word  (digest_if.digest_word),
        .last_word    (digest_if.last_word),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one beat on the message channel, preceded by a random gap that may be empty
    task automatic send_word(input sbc_pkg::word_t w, input logic first);
        int unsigned gap;
        if (burst_left != 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = gap_len();
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(16, 48);
        end
        if (gap != 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.message_word <= w;
        msg_if.restart      <= first;
        do
            @(posedge clk);
        while (!msg_if.ready);
        words_sent++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_if.ready <= 1'b0;
            calm_left  = 0;
            stall_left = 0;
        end
        else if (calm_left != 0)
        begin
            calm_left--;
            digest_if.ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            digest_if.ready <= 1'b0;
        end
        else
        begin
            digest_if.ready <= 1'b1;
            if ($urandom_range(0, 29) == 0)
                calm_left = $urandom_range(30, 120);
            else if ($urandom_range(0, 2) == 0)
                stall_left = gap_len();
        end
    end

    initial
    begin
        int unsigned nblk;
        int unsigned cut;
        int unsigned base;
        rst_n               <= 1'b0;
        msg_if.valid        <= 1'b0;
        msg_if.message_word <= '0;
        msg_if.restart      <= 1'b0;
        words_sent = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first block straight from reset, no restart flag
        for (int k = 0; k < 16; k++)
        begin
            send_word(CORNER_BLOCK[(15 - k) * 32 +: 32], 1'b0);
        end
        // partial block dropped by a second restart
        send_word(32'hffffffff, 1'b1);
        for (int k = 0; k < 5; k++)
        begin
            send_word(sbc_pkg::word_t'($urandom), 1'b0);
        end
        send_word(32'h00000000, 1'b1);

        base = words_sent;
        while (words_sent < base + RANDOM_WORDS)
        begin
            nblk = $urandom_range(1, 3);
            cut  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16 * nblk - 1)
                                               : 16 * nblk;
            for (int k = 0; k < cut; k++)
            begin
                send_word(sbc_pkg::word_t'($urandom),
                          (k == 0) ? ($urandom_range(0, 7) != 0)
                                   : ($urandom_range(0, 49) == 0));
            end
        end
        msg_if.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("tb_sha256_block_compressor_top: PASS");
        else
            $display("tb_sha256_block_compressor_top: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_sha256_block_compressor_top: FAIL");
        $finish;
    end

endmodule

// ===== sha256_block_compressor_top.f =====
sv/sbc_pkg.sv
sv/sbc_in_if.sv
sv/sbc_out_if.sv
sv/sbc_ctrl.sv
sv/sbc_datapath.sv
sv/sha256_block_compressor_top.sv
sim/sbc_digest_checker.sv
sim/tb_sha256_block_compressor_top.sv
